// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge out of reset
`define PT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true at a clock edge out of reset
`define PT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/pt2d_pkg.sv -----
// ----------------------------------------------------------------------------
// pt2d_pkg
// Types, widths, constants and helpers for the 2D scale/rotate/translate block.
// ----------------------------------------------------------------------------
package pt2d_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int COORD_W      = 32;
    localparam int ANGLE_W      = 16;
    localparam int PHASE_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int CORDIC_W     = 34;
    localparam int TRIG_W       = 32;
    localparam int TRIG_FRAC    = 30;

    localparam int SCL_W  = 2 * COORD_W;        // scale product
    localparam int WIDE_W = COORD_W + 1;        // clamped intermediate
    localparam int PROD_W = TRIG_W + WIDE_W;    // rotation product
    localparam int RSUM_W = PROD_W + 1;         // rotation sum
    localparam int RSH_W  = RSUM_W - TRIG_FRAC; // rotation sum after rescale
    localparam int FWD_W  = RSH_W + 1;          // plus translation

    localparam int QW      = COORD_W;           // quotient bits kept
    localparam int NUM_W   = COORD_W + 1 + FRAC_BITS;
    localparam int CMP_W   = COORD_W + QW;
    localparam int DRES_W  = QW + 2;
    localparam int DIV_LAT = QW + 1;

    localparam int EPS_RECIP = 1000000;
    localparam int TINY_LIM  = (2 ** FRAC_BITS + EPS_RECIP - 1) / EPS_RECIP;

    localparam longint WIDE_MAX = (64'sd1 <<< (WIDE_W - 1)) - 64'sd1;
    localparam logic signed [FWD_W-1:0] NARROW_MAX = (FWD_W'(1) <<< (COORD_W - 1)) - 1;
    localparam logic signed [FWD_W-1:0] NARROW_MIN = -(FWD_W'(1) <<< (COORD_W - 1));

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
    localparam logic signed [CORDIC_W-1:0] ONE_TRIG    = CORDIC_W'(1) <<< TRIG_FRAC;
    localparam logic [PHASE_W-1:0] PHASE_MASK =
        ~((PHASE_W'(1) << (PHASE_W - ANGLE_BITS)) - PHASE_W'(1));
    localparam logic [PHASE_W-1:0] PHASE_QUARTER = PHASE_W'(1) << (PHASE_W - 2);
    localparam logic [PHASE_W-1:0] PHASE_HALF    = PHASE_W'(1) << (PHASE_W - 1);

    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;

    localparam logic CMD_FWD = 1'b0;
    localparam logic CMD_INV = 1'b1;

    typedef enum logic [1:0] {
        CS_LOAD,
        CS_RUN,
        CS_IDLE
    } cs_t;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      zero_scale;
        logic                      saturated;
    } out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] scale_x;
        logic signed [COORD_W-1:0] scale_y;
    } cfg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic                    cmd;
        logic                    sat;
        logic signed [FWD_W-1:0] ex;
        logic signed [FWD_W-1:0] ey;
    } mid_t;

    typedef struct packed {
        logic signed [DRES_W-1:0] value;
        logic                     tiny;
    } dres_t;

    function automatic logic [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [CORDIC_W-1:0] r;
        unique case (i)
            5'd0:    r = CORDIC_W'(32'h20000000);
            5'd1:    r = CORDIC_W'(32'h12E4051E);
            5'd2:    r = CORDIC_W'(32'h09FB385B);
            5'd3:    r = CORDIC_W'(32'h051111D4);
            5'd4:    r = CORDIC_W'(32'h028B0D43);
            5'd5:    r = CORDIC_W'(32'h0145D7E1);
            5'd6:    r = CORDIC_W'(32'h00A2F61E);
            5'd7:    r = CORDIC_W'(32'h00517C55);
            5'd8:    r = CORDIC_W'(32'h0028BE53);
            5'd9:    r = CORDIC_W'(32'h00145F2F);
            5'd10:   r = CORDIC_W'(32'h000A2F98);
            5'd11:   r = CORDIC_W'(32'h000517CC);
            5'd12:   r = CORDIC_W'(32'h00028BE6);
            5'd13:   r = CORDIC_W'(32'h000145F3);
            5'd14:   r = CORDIC_W'(32'h0000A2FA);
            5'd15:   r = CORDIC_W'(32'h0000517D);
            5'd16:   r = CORDIC_W'(32'h000028BE);
            5'd17:   r = CORDIC_W'(32'h0000145F);
            5'd18:   r = CORDIC_W'(32'h00000A30);
            5'd19:   r = CORDIC_W'(32'h00000518);
            5'd20:   r = CORDIC_W'(32'h0000028C);
            5'd21:   r = CORDIC_W'(32'h00000146);
            5'd22:   r = CORDIC_W'(32'h000000A3);
            5'd23:   r = CORDIC_W'(32'h00000051);
            5'd24:   r = CORDIC_W'(32'h00000029);
            5'd25:   r = CORDIC_W'(32'h00000014);
            5'd26:   r = CORDIC_W'(32'h0000000A);
            5'd27:   r = CORDIC_W'(32'h00000005);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic over_wide(input logic signed [SCL_W-1:0] v);
        return (v > WIDE_MAX) || (v < -WIDE_MAX);
    endfunction

    function automatic logic signed [WIDE_W-1:0] clamp_wide(input logic signed [SCL_W-1:0] v);
        logic signed [SCL_W-1:0] r;
        if (v > WIDE_MAX)
            r = WIDE_MAX;
        else if (v < -WIDE_MAX)
            r = -WIDE_MAX;
        else
            r = v;
        return WIDE_W'(r);
    endfunction

    function automatic logic over_narrow(input logic signed [FWD_W-1:0] v);
        return (v > NARROW_MAX) || (v < NARROW_MIN);
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_narrow(input logic signed [FWD_W-1:0] v);
        logic signed [FWD_W-1:0] r;
        if (v > NARROW_MAX)
            r = NARROW_MAX;
        else if (v < NARROW_MIN)
            r = NARROW_MIN;
        else
            r = v;
        return COORD_W'(r);
    endfunction

endpackage

// ----- sv/pt2d_cordic.sv -----
// ----------------------------------------------------------------------------
// pt2d_cordic
// Iterative CORDIC: one rotation step per cycle, gives cos and sin in Q2.30.
// ----------------------------------------------------------------------------
module pt2d_cordic import pt2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ANGLE_W-1:0] angle,
    output trig_t              trig,
    output logic               busy
);

    cs_t                        state_reg, state_next;
    logic [STEP_W-1:0]          step_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                       flip_reg;
    logic signed [TRIG_W-1:0]   cos_reg, sin_reg;

    logic [PHASE_W-1:0]         phase, phase_q, phase_u;
    logic                       flip_w;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] x_step, y_step, z_step, at;
    logic signed [CORDIC_W-1:0] x_fin, y_fin, cos_c, sin_c;
    logic                       last_step;

    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        if (start)
            state_next = CS_LOAD;
        else
        begin
            unique case (state_reg)
                CS_LOAD: state_next = CS_RUN;
                CS_RUN:  state_next = last_step ? CS_IDLE : CS_RUN;
                CS_IDLE: state_next = CS_IDLE;
                default: state_next = CS_LOAD;
            endcase
        end
    end

    always_comb
    begin
        busy = (state_reg != CS_IDLE);
    end

    always_comb
    begin
        // angle to the top of a 32-bit phase, fold into the right half plane
        phase   = (PHASE_W'(angle) << (PHASE_W - ANGLE_W)) & PHASE_MASK;
        phase_q = phase + PHASE_QUARTER;
        flip_w  = phase_q[PHASE_W-1];
        phase_u = flip_w ? (phase ^ PHASE_HALF) : phase;
        z_init  = CORDIC_W'($signed(phase_u));

        at = $signed(atan_turn(step_reg));
        if (!z_reg[CORDIC_W-1])
        begin
            x_step = x_reg - (y_reg >>> step_reg);
            y_step = y_reg + (x_reg >>> step_reg);
            z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + (y_reg >>> step_reg);
            y_step = y_reg - (x_reg >>> step_reg);
            z_step = z_reg + at;
        end

        x_fin = flip_reg ? -x_step : x_step;
        y_fin = flip_reg ? -y_step : y_step;
        if (x_fin > ONE_TRIG)
            cos_c = ONE_TRIG;
        else if (x_fin < -ONE_TRIG)
            cos_c = -ONE_TRIG;
        else
            cos_c = x_fin;
        if (y_fin > ONE_TRIG)
            sin_c = ONE_TRIG;
        else if (y_fin < -ONE_TRIG)
            sin_c = -ONE_TRIG;
        else
            sin_c = y_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CS_LOAD)
                step_reg <= '0;
            else if (state_reg == CS_RUN)
                step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CS_LOAD)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_init;
            flip_reg <= flip_w;
        end
        else if (state_reg == CS_RUN)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
            if (last_step)
            begin
                cos_reg <= TRIG_W'(cos_c);
                sin_reg <= TRIG_W'(sin_c);
            end
        end
    end

    assign trig.cos_v = cos_reg;
    assign trig.sin_v = sin_reg;

endmodule

// ----- sv/pt2d_rot.sv -----
// ----------------------------------------------------------------------------
// pt2d_rot
// Five-stage datapath: scale or offset, rescale, rotate products, rotate sums,
// translate or clamp.
// ----------------------------------------------------------------------------
module pt2d_rot import pt2d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  in_t   item,
    input  cfg_t  cfg,
    input  trig_t trig,
    output logic  out_valid,
    output mid_t  mid
);

    localparam logic signed [SCL_W-1:0]  RND_F = SCL_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RSUM_W-1:0] RND_T = RSUM_W'(1) <<< (TRIG_FRAC - 1);

    // valid and mode bits per stage
    logic [4:0] v_reg;
    logic [3:0] cmd_reg;
    logic [2:0] sat_reg;

    logic signed [SCL_W-1:0]  ax_reg, ay_reg, ax_next, ay_next;
    logic signed [WIDE_W-1:0] bx_reg, by_reg, bx_next, by_next;
    logic                     bsat_next;
    logic signed [PROD_W-1:0] pcx_reg, psy_reg, psx_reg, pcy_reg;
    logic signed [RSH_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic signed [FWD_W-1:0]  ex_reg, ey_reg, ex_next, ey_next;
    logic                     esat_next, esat_reg;

    logic signed [WIDE_W-1:0] diff_x, diff_y;
    logic signed [SCL_W-1:0]  rs_x, rs_y;
    logic signed [RSUM_W-1:0] sum_x, sum_y;

    // stage A
    always_comb
    begin
        diff_x = WIDE_W'(item.point_x) - WIDE_W'(cfg.pos_x);
        diff_y = WIDE_W'(item.point_y) - WIDE_W'(cfg.pos_y);
        if (item.cmd == CMD_FWD)
        begin
            ax_next = item.point_x * cfg.scale_x;
            ay_next = item.point_y * cfg.scale_y;
        end
        else
        begin
            ax_next = SCL_W'(diff_x);
            ay_next = SCL_W'(diff_y);
        end
    end

    // stage B
    always_comb
    begin
        rs_x = (ax_reg + RND_F) >>> FRAC_BITS;
        rs_y = (ay_reg + RND_F) >>> FRAC_BITS;
        if (cmd_reg[0] == CMD_FWD)
        begin
            bx_next   = clamp_wide(rs_x);
            by_next   = clamp_wide(rs_y);
            bsat_next = over_wide(rs_x) | over_wide(rs_y);
        end
        else
        begin
            bx_next   = WIDE_W'(ax_reg);
            by_next   = WIDE_W'(ay_reg);
            bsat_next = 1'b0;
        end
    end

    // stage D
    always_comb
    begin
        if (cmd_reg[2] == CMD_FWD)
        begin
            sum_x = RSUM_W'(pcx_reg) - RSUM_W'(psy_reg);
            sum_y = RSUM_W'(psx_reg) + RSUM_W'(pcy_reg);
        end
        else
        begin
            sum_x = RSUM_W'(pcx_reg) + RSUM_W'(psy_reg);
            sum_y = RSUM_W'(pcy_reg) - RSUM_W'(psx_reg);
        end
        dx_next = RSH_W'((sum_x + RND_T) >>> TRIG_FRAC);
        dy_next = RSH_W'((sum_y + RND_T) >>> TRIG_FRAC);
    end

    // stage E
    always_comb
    begin
        if (cmd_reg[3] == CMD_FWD)
        begin
            ex_next   = FWD_W'(dx_reg) + FWD_W'(cfg.pos_x);
            ey_next   = FWD_W'(dy_reg) + FWD_W'(cfg.pos_y);
            esat_next = sat_reg[2];
        end
        else
        begin
            ex_next   = FWD_W'(clamp_wide(SCL_W'(dx_reg)));
            ey_next   = FWD_W'(clamp_wide(SCL_W'(dy_reg)));
            esat_next = sat_reg[2] | over_wide(SCL_W'(dx_reg)) | over_wide(SCL_W'(dy_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg  <= {cmd_reg[2:0], item.cmd};
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            bx_reg   <= bx_next;
            by_reg   <= by_next;
            sat_reg  <= {sat_reg[1:0], bsat_next};
            pcx_reg  <= trig.cos_v * bx_reg;
            psy_reg  <= trig.sin_v * by_reg;
            psx_reg  <= trig.sin_v * bx_reg;
            pcy_reg  <= trig.cos_v * by_reg;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            esat_reg <= esat_next;
        end
    end

    assign out_valid = v_reg[4];

    // cmd of stage E is the one shifted past stage D
    logic cmd_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            cmd_e_reg <= cmd_reg[3];
    end

    assign mid.cmd = cmd_e_reg;
    assign mid.sat = esat_reg;
    assign mid.ex  = ex_reg;
    assign mid.ey  = ey_reg;

endmodule

// ----- sv/pt2d_div.sv -----
// ----------------------------------------------------------------------------
// pt2d_div
// Pipelined restoring divider, one quotient bit per stage, rounds to nearest
// with ties away from zero. Quotients past the 32-bit range come out with an
// overflow bit set above the quotient bits.
// ----------------------------------------------------------------------------
module pt2d_div import pt2d_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [FWD_W-1:0]   num,
    input  logic signed [COORD_W-1:0] den,
    output dres_t                     res
);

    logic [NUM_W-1:0] rem_reg  [0:QW];
    logic [QW-1:0]    q_reg    [0:QW];
    logic             neg_reg  [0:QW];
    logic             ovf_reg  [0:QW];
    logic             tiny_reg [0:QW];

    logic signed [WIDE_W-1:0] nv, nabs;
    logic [COORD_W-1:0]       dabs;
    logic [NUM_W-1:0]         an;
    logic                     ovf_w, tiny_w, neg_w;

    always_comb
    begin
        nv     = WIDE_W'(num);
        nabs   = nv[WIDE_W-1] ? -nv : nv;
        dabs   = den[COORD_W-1] ? COORD_W'(-den) : COORD_W'(den);
        // numerator scaled up, plus half the divisor for rounding
        an     = (NUM_W'(nabs[COORD_W-1:0]) << FRAC_BITS) + NUM_W'(dabs >> 1);
        ovf_w  = CMP_W'(an) >= (CMP_W'(dabs) << QW);
        tiny_w = dabs < COORD_W'(TINY_LIM);
        neg_w  = nv[WIDE_W-1] ^ den[COORD_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= an;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg_w;
            ovf_reg[0]  <= ovf_w;
            tiny_reg[0] <= tiny_w;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++)
        begin : g_bit
            logic [CMP_W-1:0] dsh, rz;
            logic             ge;

            always_comb
            begin
                dsh = CMP_W'(dabs) << (QW - 1 - gi);
                rz  = CMP_W'(rem_reg[gi]);
                ge  = (rz >= dsh);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[gi+1]  <= ge ? NUM_W'(rz - dsh) : rem_reg[gi];
                    q_reg[gi+1]    <= {q_reg[gi][QW-2:0], ge};
                    neg_reg[gi+1]  <= neg_reg[gi];
                    ovf_reg[gi+1]  <= ovf_reg[gi];
                    tiny_reg[gi+1] <= tiny_reg[gi];
                end
            end
        end
    endgenerate

    logic signed [DRES_W-1:0] mag;

    always_comb
    begin
        mag = $signed({1'b0, ovf_reg[QW], q_reg[QW]});
        if (tiny_reg[QW])
            res.value = '0;
        else if (neg_reg[QW])
            res.value = -mag;
        else
            res.value = mag;
        res.tiny = tiny_reg[QW];
    end

endmodule

// ----- sv/point_transform_2d_srt_top.sv -----
// ----------------------------------------------------------------------------
// point_transform_2d_srt_top
// 2D point transform, scale/rotate/translate forward or inverse, Q16.16.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  point     in         point_valid / point_stall  in_t  {cmd, point_x, point_y}
//  result    out        result_valid / result_stall out_t {out_x, out_y, flags}
//  cfg       in         cfg_we                     cfg_index, cfg_data
//
//  One item per cycle while point_stall is low, through the rot and divider
//  stages and the output register to result_valid. Reset and every angle
//  write start a sine/cosine iteration (a load state plus 28 steps);
//  point_stall stays high until it is done. A stalled output parks one item
//  in a skid register; the pipeline holds only while that register is full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_transform_2d_srt_top import pt2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  in_t                  point,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_t                 result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, scale_x_reg, scale_y_reg;
    logic [ANGLE_W-1:0] angle_reg;
    cfg_t               cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            angle_reg   <= '0;
            scale_x_reg <= COORD_W'(1) << FRAC_BITS;
            scale_y_reg <= COORD_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_data;
                REG_POS_Y:   pos_y_reg   <= cfg_data;
                REG_ANGLE:   angle_reg   <= cfg_data[ANGLE_W-1:0];
                REG_SCALE_X: scale_x_reg <= cfg_data;
                REG_SCALE_Y: scale_y_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg.pos_x   = $signed(pos_x_reg);
    assign cfg.pos_y   = $signed(pos_y_reg);
    assign cfg.scale_x = $signed(scale_x_reg);
    assign cfg.scale_y = $signed(scale_y_reg);

    logic  trig_start, busy;
    trig_t trig;

    assign trig_start = cfg_we && (cfg_index == REG_ANGLE);

    pt2d_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (angle_reg),
        .trig  (trig),
        .busy  (busy)
    );

    logic en, acc;
    logic skid_v_reg, out_v_reg;
    out_t skid_reg, out_reg;

    assign en          = !skid_v_reg;
    assign point_stall = !en || busy || trig_start;
    assign acc         = point_valid && !point_stall;

    logic rot_valid;
    mid_t rot_mid;

    pt2d_rot u_rot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (acc),
        .item      (point),
        .cfg       (cfg),
        .trig      (trig),
        .out_valid (rot_valid),
        .mid       (rot_mid)
    );

    dres_t div_x, div_y;

    pt2d_div u_div_x
    (
        .clk (clk),
        .en  (en),
        .num (rot_mid.ex),
        .den (cfg.scale_x),
        .res (div_x)
    );

    pt2d_div u_div_y
    (
        .clk (clk),
        .en  (en),
        .num (rot_mid.ey),
        .den (cfg.scale_y),
        .res (div_y)
    );

    // side line keeps forward results and flags aligned with the dividers
    logic [DIV_LAT-1:0] side_v_reg;
    mid_t               side_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_v_reg <= '0;
        else if (en)
            side_v_reg <= {side_v_reg[DIV_LAT-2:0], rot_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= rot_mid;
            for (int i = 1; i < DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    mid_t                    last;
    logic signed [FWD_W-1:0] fx, fy;
    logic                    inc;
    out_t                    res_next;

    always_comb
    begin
        last = side_reg[DIV_LAT-1];
        inc  = side_v_reg[DIV_LAT-1] && en;
        if (last.cmd == CMD_FWD)
        begin
            fx = last.ex;
            fy = last.ey;
            res_next.zero_scale = 1'b0;
        end
        else
        begin
            fx = FWD_W'(div_x.value);
            fy = FWD_W'(div_y.value);
            res_next.zero_scale = div_x.tiny | div_y.tiny;
        end
        res_next.out_x     = clamp_narrow(fx);
        res_next.out_y     = clamp_narrow(fy);
        res_next.saturated = last.sat | over_narrow(fx) | over_narrow(fy);
    end

    logic out_free, out_held;

    assign out_free = !out_v_reg || !result_stall;
    assign out_held = result_valid && result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= inc;
        end
        else if (inc)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (inc)
                out_reg <= res_next;
        end
        else if (inc)
            skid_reg <= res_next;
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

    `PT_ASSERT(a_skid_behind_out, skid_v_reg |-> out_v_reg, "skid full with output empty")
    `PT_ASSERT(a_skid_fill, $rose(skid_v_reg) |-> $past(out_held), "skid filled, output free")
    `PT_NEVER(a_no_accept_busy, acc && busy, "item accepted during sine/cosine update")

endmodule
